### rtl/rbrm_pkg.sv
// ============================================================================
// rbrm_pkg
// Shared types and band table for the amateur band retune mapper.
// ============================================================================
package rbrm_pkg;

   localparam int BAND_COUNT = 7;
   localparam int IDX_W      = 3;   // holds a band index 0..BAND_COUNT-1
   localparam int FREQ_W     = 32;
   localparam int METERS_W   = 8;
   localparam int CHAR_W     = 7;
   localparam int RANGE_W    = 21;  // widest band span 1.7 MHz, also offset width
   localparam int PROD_W     = 2 * RANGE_W;
   localparam int SUM_W      = 25;  // scaled offset plus target lower edge
   localparam int DIV_STAGES = RANGE_W;

   // floor(v / 100) = (v * ceil(2^32 / 100)) >> 32, exact for v < 2^30
   localparam int                DIV100_SHIFT = 32;
   localparam int                MAGIC_W      = 26;
   localparam logic [MAGIC_W-1:0] DIV100_MAGIC = 26'd42949673;
   localparam int                QUO100_W     = SUM_W + MAGIC_W - DIV100_SHIFT;
   localparam logic [FREQ_W-1:0] STEP_HZ      = 32'd100;

   localparam logic [CHAR_W-1:0] UNKNOWN_CHAR = 7'h3F;   // '?'

   localparam logic [FREQ_W-1:0] BAND_LO [0:BAND_COUNT-1] = '{
      32'd3500000, 32'd7000000, 32'd10100000, 32'd14000000,
      32'd18068000, 32'd21000000, 32'd28000000 };

   localparam logic [FREQ_W-1:0] BAND_HI [0:BAND_COUNT-1] = '{
      32'd4000000, 32'd7300000, 32'd10150000, 32'd14350000,
      32'd18168000, 32'd21450000, 32'd29700000 };

   // lower edge plus half the span, rounded down to 100 Hz
   localparam logic [FREQ_W-1:0] BAND_MID [0:BAND_COUNT-1] = '{
      32'd3750000, 32'd7150000, 32'd10125000, 32'd14175000,
      32'd18118000, 32'd21225000, 32'd28850000 };

   localparam logic [METERS_W-1:0] BAND_WAVE_M [0:BAND_COUNT-1] = '{
      8'd80, 8'd40, 8'd30, 8'd20, 8'd17, 8'd15, 8'd10 };

   localparam logic [CHAR_W-1:0] BAND_C0 [0:BAND_COUNT-1] = '{
      7'h38, 7'h34, 7'h33, 7'h32, 7'h31, 7'h31, 7'h31 };

   localparam logic [CHAR_W-1:0] BAND_C1 [0:BAND_COUNT-1] = '{
      7'h30, 7'h30, 7'h30, 7'h30, 7'h37, 7'h35, 7'h30 };

   typedef struct packed {
      logic [FREQ_W-1:0]   frequency;
      logic [METERS_W-1:0] target_meters;
   } req_word_type;

   typedef struct packed {
      logic [FREQ_W-1:0] new_frequency;
      logic [IDX_W-1:0]  cur_band_idx;
      logic              current_known;
      logic              target_known;
      logic              in_target_band;
      logic [CHAR_W-1:0] name_first_char;
      logic [CHAR_W-1:0] name_second_char;
   } rsp_word_type;

   // result fields settled at lookup, plus what the scaling path still needs
   typedef struct packed {
      rsp_word_type      word;
      logic              use_div;
      logic [SUM_W-1:0]  tgt_lo;
   } side_type;

endpackage

### rtl/radio_band_retune_mapper.sv
// ============================================================================
// radio_band_retune_mapper
// Moves a frequency into a target amateur band, keeping its relative spot.
// ============================================================================
// Pipeline: 26 register stages, A, B, 21 divider stages, C, D and output E;
//   a request word accepted into A moves through them in that order.
// Throughput: one word per cycle while not stalled; the 21-stage
//   restoring divider for the in-band offset takes one quotient per cycle.
// Reset: synchronous, clears all stage valid bits; payload is not reset.
module radio_band_retune_mapper (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rbrm_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rbrm_pkg::rsp_word_type rsp_data
);

   localparam int RW = rbrm_pkg::RANGE_W;
   localparam int NS = rbrm_pkg::DIV_STAGES;

   // Whole pipe moves together; it advances whenever the output register
   // is empty or being drained, so bubbles never block a new word.
   logic advance;

   // ---- stage A: band lookup -------------------------------------------
   logic                     a_valid_ff;
   rbrm_pkg::side_type       a_side_ff,  a_side_in;
   logic [RW-1:0]            a_off_ff,   a_off_in;    // f - current lower edge, 0 if a band is unknown
   logic [RW-1:0]            a_rt_ff,    a_rt_in;     // target span
   logic [RW-1:0]            a_rc_ff,    a_rc_in;     // current span (divisor)

   // ---- stage B: offset times target span ------------------------------
   logic                     b_valid_ff;
   rbrm_pkg::side_type       b_side_ff;
   logic [rbrm_pkg::PROD_W-1:0] b_prod_ff;
   logic [RW-1:0]            b_rc_ff;

   // ---- divider stages, one quotient bit each --------------------------
   logic                     div_valid_ff [0:NS-1];
   rbrm_pkg::side_type       div_side_ff  [0:NS-1];
   logic [RW-1:0]            div_rem_ff   [0:NS-1], div_rem_in [0:NS-1];
   logic [RW-1:0]            div_low_ff   [0:NS-1], div_low_in [0:NS-1];
   logic [RW-1:0]            div_quo_ff   [0:NS-1], div_quo_in [0:NS-1];
   logic [RW-1:0]            div_rc_ff    [0:NS-1];

   // ---- stage C: add target lower edge ---------------------------------
   logic                     c_valid_ff;
   rbrm_pkg::side_type       c_side_ff;
   logic [rbrm_pkg::SUM_W-1:0] c_sum_ff, c_sum_in;

   // ---- stage D: divide by 100 via reciprocal --------------------------
   logic                     d_valid_ff;
   rbrm_pkg::side_type       d_side_ff;
   logic [rbrm_pkg::QUO100_W-1:0] d_quo_ff, d_quo_in;
   logic [rbrm_pkg::SUM_W+rbrm_pkg::MAGIC_W-1:0] d_prod;

   // ---- stage E: output register ---------------------------------------
   logic                     rsp_valid_ff;
   rbrm_pkg::rsp_word_type   rsp_data_ff, rsp_data_in;
   logic [rbrm_pkg::FREQ_W-1:0] e_scaled;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Stage A: match target meters and frequency against the table. Bands do
   // not overlap and meters are unique; the downward loop keeps the lowest
   // matching index anyway.
   always_comb begin
      logic [rbrm_pkg::IDX_W-1:0]  ti, ci;
      logic                        tk, ck;
      logic [rbrm_pkg::FREQ_W-1:0] f;
      ti = '0;
      ci = '0;
      tk = 1'b0;
      ck = 1'b0;
      f  = req_data.frequency;
      for (int i = rbrm_pkg::BAND_COUNT - 1; i >= 0; i--) begin
         if (req_data.target_meters == rbrm_pkg::BAND_WAVE_M[i]) begin
            ti = rbrm_pkg::IDX_W'(i);
            tk = 1'b1;
         end
         if (f >= rbrm_pkg::BAND_LO[i] && f <= rbrm_pkg::BAND_HI[i]) begin
            ci = rbrm_pkg::IDX_W'(i);
            ck = 1'b1;
         end
      end

      a_rt_in  = RW'(rbrm_pkg::BAND_HI[ti] - rbrm_pkg::BAND_LO[ti]);
      a_rc_in  = RW'(rbrm_pkg::BAND_HI[ci] - rbrm_pkg::BAND_LO[ci]);
      a_off_in = (tk && ck) ? RW'(f - rbrm_pkg::BAND_LO[ci]) : '0;

      a_side_in.use_div = tk && ck;
      a_side_in.tgt_lo  = rbrm_pkg::SUM_W'(rbrm_pkg::BAND_LO[ti]);

      // unknown target: pass through; unknown current: target midpoint
      a_side_in.word.new_frequency      = tk ? rbrm_pkg::BAND_MID[ti] : f;
      a_side_in.word.cur_band_idx       = ci;
      a_side_in.word.current_known      = ck;
      a_side_in.word.target_known       = tk;
      a_side_in.word.in_target_band     = tk && (f >= rbrm_pkg::BAND_LO[ti])
                                             && (f <= rbrm_pkg::BAND_HI[ti]);
      a_side_in.word.name_first_char    = ck ? rbrm_pkg::BAND_C0[ci]
                                             : rbrm_pkg::UNKNOWN_CHAR;
      a_side_in.word.name_second_char   = ck ? rbrm_pkg::BAND_C1[ci]
                                             : rbrm_pkg::UNKNOWN_CHAR;
   end

   // Restoring division. The quotient never exceeds the target span, so the
   // top RW product bits are already below the divisor and RW steps suffice.
   always_comb begin
      logic [RW-1:0] src_rem, src_low, src_quo, src_rc;
      logic [RW:0]   trial;
      for (int k = 0; k < NS; k++) begin
         if (k == 0) begin
            src_rem = b_prod_ff[rbrm_pkg::PROD_W-1:RW];
            src_low = b_prod_ff[RW-1:0];
            src_quo = '0;
            src_rc  = b_rc_ff;
         end else begin
            src_rem = div_rem_ff[k-1];
            src_low = div_low_ff[k-1];
            src_quo = div_quo_ff[k-1];
            src_rc  = div_rc_ff[k-1];
         end
         trial = {src_rem, src_low[RW-1]};
         if (trial >= {1'b0, src_rc}) begin
            div_rem_in[k] = RW'(trial - {1'b0, src_rc});
            div_quo_in[k] = {src_quo[RW-2:0], 1'b1};
         end else begin
            div_rem_in[k] = trial[RW-1:0];
            div_quo_in[k] = {src_quo[RW-2:0], 1'b0};
         end
         div_low_in[k] = {src_low[RW-2:0], 1'b0};
      end
   end

   assign c_sum_in = {{(rbrm_pkg::SUM_W - RW){1'b0}}, div_quo_ff[NS-1]}
                     + div_side_ff[NS-1].tgt_lo;

   assign d_prod   = {{rbrm_pkg::MAGIC_W{1'b0}}, c_sum_ff}
                     * {{rbrm_pkg::SUM_W{1'b0}}, rbrm_pkg::DIV100_MAGIC};
   assign d_quo_in = d_prod[rbrm_pkg::SUM_W+rbrm_pkg::MAGIC_W-1:rbrm_pkg::DIV100_SHIFT];

   assign e_scaled = rbrm_pkg::FREQ_W'(d_quo_ff) * rbrm_pkg::STEP_HZ;

   always_comb begin
      rsp_data_in = d_side_ff.word;
      if (d_side_ff.use_div) begin
         rsp_data_in.new_frequency = e_scaled;
      end
   end

   // Valid bits: cleared by reset, shift with the pipe.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NS; k++) begin
            div_valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         a_valid_ff      <= req_valid;
         b_valid_ff      <= a_valid_ff;
         div_valid_ff[0] <= b_valid_ff;
         for (int k = 1; k < NS; k++) begin
            div_valid_ff[k] <= div_valid_ff[k-1];
         end
         c_valid_ff   <= div_valid_ff[NS-1];
         d_valid_ff   <= c_valid_ff;
         rsp_valid_ff <= d_valid_ff;
      end
   end

   // Payload registers: no reset, hold while stalled.
   always_ff @(posedge clock) begin
      if (advance) begin
         a_side_ff <= a_side_in;
         a_off_ff  <= a_off_in;
         a_rt_ff   <= a_rt_in;
         a_rc_ff   <= a_rc_in;

         b_side_ff <= a_side_ff;
         b_prod_ff <= rbrm_pkg::PROD_W'(a_off_ff) * rbrm_pkg::PROD_W'(a_rt_ff);
         b_rc_ff   <= a_rc_ff;

         div_side_ff[0] <= b_side_ff;
         div_rc_ff[0]   <= b_rc_ff;
         for (int k = 1; k < NS; k++) begin
            div_side_ff[k] <= div_side_ff[k-1];
            div_rc_ff[k]   <= div_rc_ff[k-1];
         end
         for (int k = 0; k < NS; k++) begin
            div_rem_ff[k]  <= div_rem_in[k];
            div_low_ff[k]  <= div_low_in[k];
            div_quo_ff[k]  <= div_quo_in[k];
         end

         c_side_ff   <= div_side_ff[NS-1];
         c_sum_ff    <= c_sum_in;
         d_side_ff   <= c_side_ff;
         d_quo_ff    <= d_quo_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
